>>> hw/rtl/sbqm_pkg.sv
// Shared types and constants for the semaphore blocked queue manager.
package sbqm_pkg;
	localparam int MaxProcs = 32;
	localparam int IdxW = $clog2(MaxProcs);
	localparam int ProcW = 5;
	localparam int KeyW = 31;

	typedef enum logic [1:0] {
		OP_BLOCK = 2'd0, OP_RELEASE = 2'd1, OP_REMOVE = 2'd2, OP_PEEK = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_NO_FREE = 2'd1, ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KeyW-1:0]  sem_addr;
		logic [ProcW-1:0] proc_id;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             proc_valid;
		logic [ProcW-1:0] proc_out;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture command
		logic scan;     // start key search
		logic exec;     // apply the update and build the result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
	} dp_sts_t;
endpackage

>>> hw/rtl/semaphore_blocked_queue_manager_core.sv
// Top level of the semaphore blocked queue manager.
//  channel | handshake          | word
//  cmd     | start && !busy     | cmd_t  (opcode, sem_addr, proc_id)
//  rsp     | done, one cycle    | rsp_t  (status, proc_valid, proc_out)
// An item passes through capture, key compare, priority pick and update in turn.
// The result strobe rises in the cycle after the update, as busy falls.
// Reset clears the in-use and blocked flags; other stores are written before read.
// The receiver cannot stall; each result is strobed for one cycle only.
module semaphore_blocked_queue_manager_core import sbqm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t rsp
);
	dp_cmd_t ctl;
	dp_sts_t sts;
	rsp_t    rsp_c;
	logic    exec_q;

	sbqm_ctrl u_ctrl (.clk, .arst_n, .start, .sts, .busy, .ctl, .exec_q);
	sbqm_datapath u_dp (.clk, .arst_n, .cmd, .ctl, .sts, .rsp(rsp_c));

	// hold the result word for its strobe cycle
	always_ff @(posedge clk) if (ctl.exec) rsp <= rsp_c;
	assign done = exec_q;
endmodule

>>> hw/rtl/sbqm_datapath.sv
// Descriptor and link stores with key search and list update.
module sbqm_datapath import sbqm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  dp_cmd_t ctl,
	output dp_sts_t sts,
	output rsp_t    rsp
);
	logic [MaxProcs-1:0] in_use_q, blocked_q;
	logic [KeyW-1:0]     key_q [MaxProcs];
	logic [IdxW-1:0]     first_q [MaxProcs];
	logic [IdxW-1:0]     last_q [MaxProcs];
	logic [IdxW-1:0]     next_q [MaxProcs];
	logic [IdxW-1:0]     prev_q [MaxProcs];
	logic [IdxW-1:0]     owner_q [MaxProcs];
	cmd_t                c_q;
	logic [IdxW-1:0]     hit_idx_q, free_idx_q;
	logic                hit_q, free_q, scan_q;
	logic [MaxProcs-1:0] match;
	logic [MaxProcs-1:0] match_q;
	logic [IdxW-1:0]     hit_idx, free_idx;
	logic                hit, free_any;

	// registered match vector splits the compare from the priority pick
	always_comb begin
		for (int i = 0; i < MaxProcs; i++)
			match[i] = in_use_q[i] && (key_q[i] == c_q.sem_addr);
	end

	always_comb begin
		hit = 1'b0; hit_idx = '0; free_any = 1'b0; free_idx = '0;
		for (int i = MaxProcs-1; i >= 0; i--) begin
			if (match_q[i]) begin hit = 1'b1; hit_idx = IdxW'(i); end
			if (!in_use_q[i]) begin free_any = 1'b1; free_idx = IdxW'(i); end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) c_q <= cmd;
		if (ctl.scan) match_q <= match;
		if (scan_q) begin
			hit_q <= hit; hit_idx_q <= hit_idx;
			free_q <= free_any; free_idx_q <= free_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scan_q <= 1'b0;
		else scan_q <= ctl.scan;
	end
	assign sts.scan_done = scan_q;

	logic [IdxW-1:0] p, d, h, f, l;
	logic            do_unlink;
	logic [IdxW-1:0] ud, up;
	always_comb begin
		p = c_q.proc_id[IdxW-1:0];
		h = first_q[hit_idx_q];
		do_unlink = 1'b0; ud = hit_idx_q; up = h;
		if (ctl.exec) begin
			if (c_q.opcode == OP_RELEASE && hit_q) do_unlink = 1'b1;
			if (c_q.opcode == OP_REMOVE && blocked_q[p]) begin
				do_unlink = 1'b1; ud = owner_q[p]; up = p;
			end
		end
		d = ud;
		f = first_q[ud];
		l = last_q[ud];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0; blocked_q <= '0;
		end else if (ctl.exec) begin
			if (do_unlink) begin
				if (f == up && l == up) in_use_q[d] <= 1'b0;
				blocked_q[up] <= 1'b0;
			end else if (c_q.opcode == OP_BLOCK && !blocked_q[p]) begin
				if (hit_q) blocked_q[p] <= 1'b1;
				else if (free_q) begin
					blocked_q[p] <= 1'b1; in_use_q[free_idx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (do_unlink) begin
				if (f == up && l == up) begin
				end else if (f == up) first_q[d] <= next_q[up];
				else if (l == up) last_q[d] <= prev_q[up];
				else begin
					next_q[prev_q[up]] <= next_q[up];
					prev_q[next_q[up]] <= prev_q[up];
				end
			end else if (c_q.opcode == OP_BLOCK && !blocked_q[p]) begin
				if (hit_q) begin
					next_q[last_q[hit_idx_q]] <= p;
					prev_q[p] <= last_q[hit_idx_q];
					last_q[hit_idx_q] <= p;
					owner_q[p] <= hit_idx_q;
				end else if (free_q) begin
					key_q[free_idx_q] <= c_q.sem_addr;
					first_q[free_idx_q] <= p;
					last_q[free_idx_q] <= p;
					owner_q[p] <= free_idx_q;
				end
			end
		end
	end

	always_comb begin
		rsp = '{status: ST_NOT_FOUND, proc_valid: 1'b0, proc_out: '0};
		unique case (opcode_t'(c_q.opcode))
			OP_BLOCK: if (!blocked_q[p]) begin
				if (hit_q || free_q) rsp.status = ST_OK;
				else rsp.status = ST_NO_FREE;
			end
			OP_RELEASE, OP_PEEK: if (hit_q) begin
				rsp.status = ST_OK; rsp.proc_valid = 1'b1; rsp.proc_out = ProcW'(h);
			end
			OP_REMOVE: if (blocked_q[p]) begin
				rsp.status = ST_OK; rsp.proc_valid = 1'b1; rsp.proc_out = c_q.proc_id;
			end
			default: ;
		endcase
	end
endmodule

>>> hw/rtl/sbqm_ctrl.sv
// Command sequencer for the queue manager.
module sbqm_ctrl import sbqm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output logic    busy,
	output dp_cmd_t ctl,
	output logic    exec_q
);
	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT, S_EXEC} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; busy <= 1'b0; exec_q <= 1'b0;
		end else begin
			exec_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin state_q <= S_SCAN; busy <= 1'b1; end
				S_SCAN: state_q <= S_WAIT;
				S_WAIT: if (sts.scan_done) state_q <= S_EXEC;
				S_EXEC: begin state_q <= S_IDLE; busy <= 1'b0; exec_q <= 1'b1; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.load = (state_q == S_IDLE) && start;
		ctl.scan = (state_q == S_SCAN);
		ctl.exec = (state_q == S_EXEC);
	end
endmodule
